// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned PRI_W     = 4;
	localparam int unsigned CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	// command beat
	typedef struct packed {
		action_t            action;
		logic [ID_W-1:0]    proc_id;
		logic [PRI_W-1:0]   priority_req;
	} cmd_t;

	// result beat
	typedef struct packed {
		status_t              status;
		logic [ID_W-1:0]      out_id;
		logic [PRI_W-1:0]     out_priority;
		logic [CNT_OUT_W-1:0] entry_count;
	} result_t;

	// one queue slot
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// shift controls broadcast to every cell
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t new_entry;
	} ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell (
	input  logic            clk,
	input  spq_pkg::ctrl_t  ctrl,
	input  logic            occ,
	input  logic            left_place,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output logic            place,
	output spq_pkg::entry_t entry
);

	spq_pkg::entry_t entry_q;

	// new entry belongs at or before this slot
	assign place = !occ || (entry_q.pri < ctrl.new_entry.pri);
	assign entry = entry_q;

	// insert: take the new entry at the boundary, shift right past it
	// remove: shift left toward the head
	always_ff @(posedge clk) begin
		if (ctrl.enq && place) begin
			if (left_place) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= ctrl.new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Stable priority queue, highest priority at the head.
// Command channel: cmd is taken at a rising edge with start high and busy
// low. busy stays low, so a command may be issued in every cycle.
// An enqueue inserts proc_id after every held entry of equal or higher
// priority, so equal priorities leave in arrival order; a dequeue pops the
// head. A full queue rejects an enqueue, an empty one reports on dequeue.
// Result channel: done pulses for one cycle with result valid, in the cycle
// after the command beat. The receiver cannot stall; each result must
// be taken in the cycle that it is shown.
// Throughput is one command per cycle: every slot is a cell that compares
// its priority with the incoming one and shifts in one step.
// Reset empties the queue (count to zero) and clears done; slot contents
// are not cleared, since only slots below the count are ever read.
module stable_priority_queue #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spq_pkg::cmd_t    cmd,
	output logic             done,
	output spq_pkg::result_t result
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic             full, empty, enq_ok, deq_ok, fire;
	spq_pkg::ctrl_t   ctrl;
	logic             place   [DEPTH];
	spq_pkg::entry_t  entries [DEPTH];
	logic             done_q;
	spq_pkg::result_t result_q;

	assign busy  = 1'b0;
	assign fire  = start && !busy;
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign enq_ok = fire && (cmd.action == spq_pkg::ACT_ENQ) && !full;
	assign deq_ok = fire && (cmd.action == spq_pkg::ACT_DEQ) && !empty;

	assign ctrl.enq       = enq_ok;
	assign ctrl.deq       = deq_ok;
	assign ctrl.new_entry = '{id: cmd.proc_id, pri: cmd.priority_req};

	// row of slot cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic            occ_i, left_place_i;
		spq_pkg::entry_t left_i, right_i;

		assign occ_i = (CW'(i) < count_q);
		if (i == 0) begin : g_head
			assign left_place_i = 1'b0;
			assign left_i       = ctrl.new_entry;
		end else begin : g_body
			assign left_place_i = place[i-1];
			assign left_i       = entries[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_i = entries[i];
		end else begin : g_mid
			assign right_i = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ_i),
			.left_place  (left_place_i),
			.left_entry  (left_i),
			.right_entry (right_i),
			.place       (place[i]),
			.entry       (entries[i])
		);
	end

	// entry count
	always_comb begin
		count_nxt = count_q;
		if (enq_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (deq_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= fire;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.entry_count <= spq_pkg::CNT_OUT_W'(count_nxt);
			if (cmd.action == spq_pkg::ACT_ENQ) begin
				result_q.status       <= full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
				result_q.out_id       <= '0;
				result_q.out_priority <= '0;
			end else if (empty) begin
				result_q.status       <= spq_pkg::ST_EMPTY;
				result_q.out_id       <= '0;
				result_q.out_priority <= '0;
			end else begin
				result_q.status       <= spq_pkg::ST_DEQUEUED;
				result_q.out_id       <= entries[0].id;
				result_q.out_priority <= entries[0].pri;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> done) else $error("result beat missing after command");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> !done) else $error("result beat without command");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("entry count above depth");
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == spq_pkg::ST_DEQUEUED) |-> $past(!empty))
		else $error("dequeue reported from empty queue");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

// Shadow copy of the ready queue plus the results it predicts
class prio_queue_shadow;
	logic [spq_pkg::ID_W-1:0]  slot_id  [spq_pkg::DEPTH_DEF];
	logic [spq_pkg::PRI_W-1:0] slot_pri [spq_pkg::DEPTH_DEF];
	int unsigned               fill;
	spq_pkg::result_t          due_results [$];
	int unsigned               errors;

	function new();
		fill   = 0;
		errors = 0;
	endfunction

	// apply one accepted command beat and queue its result
	function void take_command(spq_pkg::cmd_t c);
		spq_pkg::result_t r;
		int unsigned      pos;
		r = '0;
		if (c.action == spq_pkg::ACT_ENQ) begin
			if (fill >= spq_pkg::DEPTH_DEF) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// insert after every entry of equal or higher priority
				pos = 0;
				while (pos < fill && slot_pri[pos] >= c.priority_req)
					pos++;
				for (int k = fill; k > int'(pos); k--) begin
					slot_id[k]  = slot_id[k-1];
					slot_pri[k] = slot_pri[k-1];
				end
				slot_id[pos]  = c.proc_id;
				slot_pri[pos] = c.priority_req;
				fill++;
				r.status = spq_pkg::ST_ENQUEUED;
			end
		end else if (fill == 0) begin
			r.status = spq_pkg::ST_EMPTY;
		end else begin
			r.status       = spq_pkg::ST_DEQUEUED;
			r.out_id       = slot_id[0];
			r.out_priority = slot_pri[0];
			for (int k = 1; k < int'(fill); k++) begin
				slot_id[k-1]  = slot_id[k];
				slot_pri[k-1] = slot_pri[k];
			end
			fill--;
		end
		r.entry_count = spq_pkg::CNT_OUT_W'(fill);
		due_results.push_back(r);
	endfunction

	// compare one result beat against the oldest prediction
	function void match_result(spq_pkg::result_t got);
		spq_pkg::result_t want;
		if (due_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: status=%0d id=%h pri=%0d count=%0d",
					got.status, got.out_id, got.out_priority, got.entry_count);
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status || got.out_id !== want.out_id ||
				got.out_priority !== want.out_priority ||
				got.entry_count !== want.entry_count) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: expected status=%0d id=%h pri=%0d count=%0d,",
					" got status=%0d id=%h pri=%0d count=%0d"},
					want.status, want.out_id, want.out_priority, want.entry_count,
					got.status, got.out_id, got.out_priority, got.entry_count);
		end
	endfunction
endclass

module tb;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned RAND_ITEMS  = 450;
	localparam int unsigned CALM_TAIL   = 60;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	spq_pkg::cmd_t    cmd;
	logic             done;
	spq_pkg::result_t result;

	prio_queue_shadow shadow;
	int unsigned      quiet_cycles = 0;

	stable_priority_queue #(
		.DEPTH(spq_pkg::DEPTH_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: results first, then the command beat taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.match_result(result);
			if (start && !busy)
				shadow.take_command(cmd);
		end
		if ((start && !busy && arst_n) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("[stable_priority_queue] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic spq_pkg::cmd_t mk(input spq_pkg::action_t act,
			input logic [spq_pkg::ID_W-1:0] id, input logic [spq_pkg::PRI_W-1:0] pri);
		spq_pkg::cmd_t c;
		c.action       = act;
		c.proc_id      = id;
		c.priority_req = pri;
		return c;
	endfunction

	// random beat; narrow priorities make ties common
	function automatic spq_pkg::cmd_t rand_cmd(input int unsigned enq_pct,
			input bit narrow);
		spq_pkg::action_t          act;
		logic [spq_pkg::PRI_W-1:0] pri;
		act = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ;
		pri = narrow ? spq_pkg::PRI_W'($urandom_range(0, 2) * 7)
			: spq_pkg::PRI_W'($urandom_range(0, 15));
		return mk(act, spq_pkg::ID_W'($urandom), pri);
	endfunction

	// hold start high until the beat is taken
	task automatic issue(input spq_pkg::cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		cmd   <= mk(spq_pkg::action_t'($urandom_range(0, 1)), spq_pkg::ID_W'($urandom),
			spq_pkg::PRI_W'($urandom));
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int unsigned idx;
		int unsigned bias;
		int unsigned run_len;
		bit          narrow;

		shadow       = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, ties, fill to full, partial drain
		issue(mk(spq_pkg::ACT_DEQ, 16'hFFFF, 4'hF));
		issue(mk(spq_pkg::ACT_ENQ, 16'h0000, 4'h0));
		issue(mk(spq_pkg::ACT_ENQ, 16'hFFFF, 4'hF));
		issue(mk(spq_pkg::ACT_ENQ, 16'h1234, 4'h7));
		issue(mk(spq_pkg::ACT_ENQ, 16'h5555, 4'h7));
		issue(mk(spq_pkg::ACT_ENQ, 16'hAAAA, 4'h7));
		issue(mk(spq_pkg::ACT_ENQ, 16'h0001, 4'hF));
		issue(mk(spq_pkg::ACT_ENQ, 16'h8000, 4'h0));
		for (int i = 0; i < 9; i++)
			issue(mk(spq_pkg::ACT_ENQ, spq_pkg::ID_W'($urandom), spq_pkg::PRI_W'(i * 5)));
		issue(mk(spq_pkg::ACT_ENQ, 16'hBEEF, 4'hF));
		issue(mk(spq_pkg::ACT_ENQ, 16'h7FFF, 4'h0));
		for (int i = 0; i < 5; i++)
			issue(mk(spq_pkg::ACT_DEQ, spq_pkg::ID_W'($urandom), spq_pkg::PRI_W'($urandom)));

		// random runs with a biased mix so full and empty are both reached
		idx = 0;
		while (idx < RAND_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       bias = 15;
				1:       bias = 50;
				default: bias = 85;
			endcase
			run_len = $urandom_range(10, 40);
			narrow  = ($urandom_range(0, 2) == 0);
			for (int j = 0; j < int'(run_len) && idx < RAND_ITEMS; j++) begin
				if (idx < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
					pause($urandom_range(1, 15));
				issue(rand_cmd(bias, narrow));
				idx++;
			end
		end

		// drain
		start <= 1'b0;
		@(posedge clk);
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (shadow.errors == 0 && shadow.due_results.size() == 0)
			$display("[stable_priority_queue] OK");
		else
			$display("[stable_priority_queue] ERROR");
		$finish;
	end
endmodule
